// File: design/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// types, codes, constants and byte-merge functions shared by the copy engine modules
// ----------------------------------------------------------------------------
package dce_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_DATA  = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_RDATA = 2'd1;
  localparam logic [1:0] KIND_BREQ  = 2'd2;
  localparam logic [1:0] KIND_BWR   = 2'd3;

  localparam logic [7:0] OFF_SOURCE = 8'd0;
  localparam logic [7:0] OFF_TARGET = 8'd4;
  localparam logic [7:0] OFF_COUNT  = 8'd8;
  localparam logic [7:0] OFF_RUN    = 8'd12;
  localparam logic [7:0] OFF_PITCH  = 8'd16;
  localparam logic [7:0] OFF_WIDTH  = 8'd20;

  localparam logic [31:0] MODE_FILL   = 32'd1;
  localparam logic [31:0] MODE_COPY   = 32'd2;
  localparam logic [31:0] MODE_STREAM = 32'd3;
  localparam logic [31:0] MODE_BLIT   = 32'd4;

  localparam logic [31:0] WORD_MASK = ~32'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reg_offset;
    logic [31:0] data_in;
    logic        target_ready;
    logic        target_next_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] data_out;
    logic        error;
    logic        dropped;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] source;
    logic [31:0] target;
    logic [31:0] pitch;
    logic [31:0] width;
    logic [31:0] count;
    logic [31:0] mode;
    logic [31:0] tag;
  } task_t;

  // controller -> datapath
  typedef struct packed {
    logic        load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       busy;
  } dp_stat_t;

  function automatic logic [31:0] merge_lo(logic [1:0] a, logic [31:0] tl, logic [31:0] v);
    case (a)
      2'd0:    merge_lo = v;
      2'd1:    merge_lo = (tl & 32'h000000ff) | ((v & 32'h00ffffff) << 8);
      2'd2:    merge_lo = (tl & 32'h0000ffff) | ((v & 32'h0000ffff) << 16);
      default: merge_lo = (tl & 32'h00ffffff) | ((v & 32'h000000ff) << 24);
    endcase
  endfunction

  function automatic logic [31:0] merge_hi(logic [1:0] a, logic [31:0] th, logic [31:0] v);
    case (a)
      2'd0:    merge_hi = th;
      2'd1:    merge_hi = (th & 32'hffffff00) | (v >> 24);
      2'd2:    merge_hi = (th & 32'hffff0000) | (v >> 16);
      default: merge_hi = (th & 32'hff000000) | (v >> 8);
    endcase
  endfunction

endpackage

// File: design/dce_queue.sv
// ----------------------------------------------------------------------------
// dce_queue
// task ring buffer; head entry held in registers, rest in memory
// ----------------------------------------------------------------------------
module dce_queue #(
  parameter int QUEUE_DEPTH = dce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dce_pkg::task_t push_task,
  input  logic           pop,
  output logic           mem_rd_valid,
  output dce_pkg::task_t mem_rd_task,
  output logic           empty
);
  import dce_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  task_t mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] used;
  logic          full;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    if (p == AW'(QUEUE_DEPTH - 1)) inc = '0;
    else inc = p + 1'b1;
  endfunction

  assign empty = (used == '0);
  assign full  = (used == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_task;
    end
    mem_rd_task <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used <= '0;
      mem_rd_valid <= 1'b0;
    end else begin
      mem_rd_valid <= 1'b0;
      if (push && !full) wr_ptr <= inc(wr_ptr);
      if (pop) begin
        rd_ptr <= inc(rd_ptr);
        mem_rd_valid <= 1'b1;
      end
      used <= used + CW'(push && !full) - CW'(pop);
    end
  end
endmodule

// File: design/dce_ctrl.sv
// ----------------------------------------------------------------------------
// dce_ctrl
// state machine: accepts a beat, sequences result beats, drives the datapath
// ----------------------------------------------------------------------------
module dce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  logic [1:0]         n_results,
  output logic [1:0]         out_idx,
  output dce_pkg::dp_cmd_t   cmd,
  input  dce_pkg::dp_stat_t  stat
);
  import dce_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OUT  = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0] state;
  logic [1:0] cnt;

  assign in_ready  = (state == S_IDLE) && !stat.busy;
  assign out_valid = (state == S_OUT);
  assign out_idx   = cnt;
  assign cmd.load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_FILL;
            cnt <= '0;
          end
        end
        S_FILL: begin
          if (n_results == 2'd0) state <= S_IDLE;
          else state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (cnt + 2'd1 == n_results) state <= S_IDLE;
            cnt <= cnt + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/dce_datapath.sv
// ----------------------------------------------------------------------------
// dce_datapath
// staging registers, task queue, head task, bus read sequencing
// ----------------------------------------------------------------------------
module dce_datapath #(
  parameter int QUEUE_DEPTH = dce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dce_pkg::in_item_t  in_item,
  input  dce_pkg::dp_cmd_t   cmd,
  output dce_pkg::dp_stat_t  stat,
  input  logic [1:0]         out_idx,
  output logic [1:0]         n_results,
  output dce_pkg::out_item_t out_item
);
  import dce_pkg::*;

  logic [31:0] stage_source, stage_target, stage_pitch, stage_width, stage_count;
  logic [31:0] queued_tag, retired_tag, head_row_offset;
  logic [1:0]  read_phase;
  logic [31:0] read_words [3];
  task_t       head;
  logic        head_valid;
  logic        head_loading;

  logic        q_push, q_pop, q_empty, q_rd_valid;
  task_t       q_push_task, q_rd_task;

  out_item_t   res [3];
  logic [1:0]  nres;
  out_item_t   res_next [3];
  logic [1:0]  nres_next;

  // queue holds tasks behind head
  logic        any_task;
  logic        full_all;
  assign any_task = head_valid;

  dce_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_task(q_push_task), .pop(q_pop),
    .mem_rd_valid(q_rd_valid), .mem_rd_task(q_rd_task),
    .empty(q_empty)
  );

  // total tasks = head + queue; queue depth covers all but requires head slot
  logic q_push_ok_c, retire_c;
  logic [$clog2(QUEUE_DEPTH + 1)-1:0] total;
  always_ff @(posedge clk) begin
    if (rst) total <= '0;
    else total <= total + ($bits(total))'(q_push_ok_c) - ($bits(total))'(retire_c);
  end
  assign full_all = (total == ($bits(total))'(QUEUE_DEPTH));

  assign stat.busy = head_loading;
  assign n_results = nres;

  always_comb begin
    out_item = res[0];
    case (out_idx)
      2'd0: out_item = res[0];
      2'd1: out_item = res[1];
      2'd2: out_item = res[2];
      default: out_item = res[0];
    endcase
    out_item.last = (out_idx + 2'd1 == nres);
  end

  // combinational step
  task_t       h_n;
  logic [31:0] wo;
  logic [31:0] hro_n, qt_n;
  logic [31:0] ss_n, st_n, sp_n, sw_n, sc_n;
  logic [1:0]  rp_n;
  logic [31:0] rw0_n, rw1_n, rw2_n;
  logic        retire_chk;
  logic [31:0] tl, th;

  always_comb begin
    h_n = head; hro_n = head_row_offset; qt_n = queued_tag;
    ss_n = stage_source; st_n = stage_target; sp_n = stage_pitch;
    sw_n = stage_width; sc_n = stage_count; rp_n = read_phase;
    rw0_n = read_words[0]; rw1_n = read_words[1]; rw2_n = read_words[2];
    q_push_ok_c = 1'b0; q_push_task = '0; retire_chk = 1'b0;
    nres_next = '0;
    for (int i = 0; i < 3; i++) res_next[i] = '0;
    wo = (head.target + head_row_offset) & WORD_MASK;
    tl = '0; th = '0;
    case (in_item.action)
      ACT_WRITE: begin
        nres_next = 2'd1;
        res_next[0].kind = KIND_ACK;
        case (in_item.reg_offset)
          OFF_SOURCE: ss_n = in_item.data_in;
          OFF_TARGET: st_n = in_item.data_in;
          OFF_PITCH:  sp_n = in_item.data_in;
          OFF_WIDTH:  sw_n = in_item.data_in;
          OFF_COUNT:  sc_n = in_item.data_in;
          OFF_RUN: begin
            if (!full_all) begin
              qt_n = queued_tag + 32'd1;
              q_push_ok_c = 1'b1;
              q_push_task = '{source: stage_source, target: stage_target,
                              pitch: stage_pitch, width: stage_width,
                              count: stage_count, mode: in_item.data_in, tag: qt_n};
            end else begin
              res_next[0].dropped = 1'b1;
            end
          end
          default: res_next[0].error = 1'b1;
        endcase
      end
      ACT_READ: begin
        nres_next = 2'd1;
        res_next[0].kind = KIND_RDATA;
        case (in_item.reg_offset)
          OFF_SOURCE: res_next[0].data_out = queued_tag;
          OFF_TARGET: res_next[0].data_out = retired_tag;
          OFF_RUN: res_next[0].data_out = {30'd0, full_all, !any_task};
          default: res_next[0].error = 1'b1;
        endcase
      end
      ACT_TICK: begin
        if (any_task && read_phase == 2'd0) begin
          if (head.count != 32'd0) begin
            case (head.mode)
              MODE_FILL: begin
                if (in_item.target_ready) begin
                  nres_next = 2'd1;
                  res_next[0] = '{kind: KIND_BWR, address: head.target,
                                  data_out: head.source, default: '0};
                  h_n.target = head.target + 32'd4;
                  h_n.count = head.count - 32'd1;
                end
              end
              MODE_COPY, MODE_STREAM: begin
                if (in_item.target_ready) begin
                  nres_next = 2'd1;
                  res_next[0] = '{kind: KIND_BREQ, address: head.source, default: '0};
                  rp_n = 2'd1;
                end
              end
              MODE_BLIT: begin
                if (in_item.target_ready && in_item.target_next_ready) begin
                  nres_next = 2'd3;
                  res_next[0] = '{kind: KIND_BREQ, address: head.source, default: '0};
                  res_next[1] = '{kind: KIND_BREQ, address: wo, default: '0};
                  res_next[2] = '{kind: KIND_BREQ, address: wo + 32'd4, default: '0};
                  rp_n = 2'd3;
                end
              end
              default: ;
            endcase
          end
          retire_chk = (rp_n == 2'd0);
        end
      end
      default: begin
        if (read_phase == 2'd0 || !any_task) begin
          rp_n = 2'd0;
        end else if (head.mode == MODE_BLIT) begin
          case (read_phase)
            2'd3: rw0_n = in_item.data_in;
            2'd2: rw1_n = in_item.data_in;
            default: rw2_n = in_item.data_in;
          endcase
          rp_n = read_phase - 2'd1;
          if (read_phase == 2'd1) begin
            tl = merge_lo(head.target[1:0], read_words[1], read_words[0]);
            th = merge_hi(head.target[1:0], in_item.data_in, read_words[0]);
            nres_next = 2'd2;
            res_next[0] = '{kind: KIND_BWR, address: wo, data_out: tl, default: '0};
            res_next[1] = '{kind: KIND_BWR, address: wo + 32'd4, data_out: th,
                            default: '0};
            h_n.source = head.source + 32'd4;
            hro_n = head_row_offset + 32'd4;
            if (hro_n >= head.width) begin
              hro_n = '0;
              h_n.target = head.target + head.pitch;
              h_n.count = head.count - 32'd1;
            end
            retire_chk = 1'b1;
          end
        end else begin
          rw0_n = in_item.data_in;
          rp_n = 2'd0;
          nres_next = 2'd1;
          res_next[0] = '{kind: KIND_BWR, address: head.target,
                          data_out: in_item.data_in, default: '0};
          if (head.mode == MODE_COPY) h_n.target = head.target + 32'd4;
          h_n.source = head.source + 32'd4;
          if (head.count != 32'd0) h_n.count = head.count - 32'd1;
          retire_chk = 1'b1;
        end
      end
    endcase
    retire_c = cmd.load && retire_chk && any_task && (h_n.count == 32'd0);
    if (!cmd.load) q_push_ok_c = 1'b0;
  end

  // head register refilled from queue when it empties; push goes straight
  // to head when nothing is queued and the head is free or retiring
  logic push_to_head;
  assign push_to_head = q_push_ok_c && (retire_c ? q_empty : (!head_valid && q_empty));
  assign q_push = q_push_ok_c && !push_to_head;
  assign q_pop  = retire_c && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_source <= '0; stage_target <= '0; stage_pitch <= '0;
      stage_width <= '0; stage_count <= '0;
      queued_tag <= '0; retired_tag <= '0; head_row_offset <= '0;
      read_phase <= '0; head_valid <= 1'b0; head_loading <= 1'b0; nres <= '0;
    end else begin
      head_loading <= q_pop;
      if (q_rd_valid) begin
        head <= q_rd_task;
        head_valid <= 1'b1;
      end
      if (cmd.load) begin
        stage_source <= ss_n; stage_target <= st_n; stage_pitch <= sp_n;
        stage_width <= sw_n; stage_count <= sc_n; queued_tag <= qt_n;
        read_phase <= rp_n;
        read_words[0] <= rw0_n; read_words[1] <= rw1_n; read_words[2] <= rw2_n;
        res <= res_next; nres <= nres_next;
        head_row_offset <= hro_n;
        if (any_task) head <= h_n;
        if (retire_c) begin
          retired_tag <= h_n.tag;
          head_row_offset <= '0;
          head_valid <= 1'b0;
        end
        if (push_to_head) begin
          head <= q_push_task;
          head_valid <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/dma_copy_engine.sv
// ----------------------------------------------------------------------------
// dma_copy_engine
// register-programmed dma master with a task queue
// ----------------------------------------------------------------------------
// One input channel carries register writes, register reads, bus ticks and
// returned bus read data, one beat per action. The output channel carries
// register acks, read data, bus read requests and bus writes; last marks the
// final beat caused by an input beat.
// An input beat is first evaluated, then its results (zero to three)
// leave one per cycle as the receiver takes them; the next input is taken
// once the final beat has gone. When a task retires and another is
// queued, the head is reloaded from the queue memory while the beat is
// evaluated, so it adds no time.
// Reset clears staging registers, tags and empties the queue. While the
// receiver stalls, the current result beat holds and no input is taken.
// ----------------------------------------------------------------------------
module dma_copy_engine #(
  parameter int QUEUE_DEPTH = dce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dce_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dce_pkg::out_item_t out_data
);
  import dce_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] n_results;
  logic [1:0] out_idx;

  dce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .n_results(n_results),
    .out_idx(out_idx), .cmd(cmd), .stat(stat)
  );

  dce_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_idx(out_idx), .n_results(n_results), .out_item(out_data)
  );
endmodule
